// ----- rtl/core/knn_price_estimator_defines.svh -----
// Assertion macros shared by the checker of the price estimator.
// Depends on nothing; the asserting file supplies clk and rst_n.
`ifndef KNN_PRICE_ESTIMATOR_DEFINES_SVH
`define KNN_PRICE_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KNN_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("knn assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define KNN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("knn assertion failed");

`endif

// ----- rtl/core/knn_pkg.sv -----
// Shared types, codes and default sizes of the price estimator.
// Depends on nothing; every module of the block imports it.
package knn_pkg;

    localparam int DEF_MAX_LISTINGS = 256;
    localparam int DEF_MAX_K        = 32;

    // Operation codes of a command transaction.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_REDUCED = 2'd2;

    // Attribute selection codes.
    localparam logic [1:0] KEY_ACCOM = 2'd0;
    localparam logic [1:0] KEY_BEDRM = 2'd1;
    localparam logic [1:0] KEY_BEDS  = 2'd2;

    // Configuration register indexes and reset values.
    localparam logic [1:0] REG_KEY_SELECT = 2'd0;
    localparam logic [1:0] REG_NEIGHBOURS = 2'd1;
    localparam logic [1:0] KEY_RESET      = 2'd0;
    localparam logic [5:0] K_RESET        = 6'd5;

    // One stored listing.
    typedef struct packed {
        logic [7:0]  accommodates;
        logic [7:0]  bedrooms;
        logic [7:0]  beds;
        logic [15:0] price;
    } listing_t;

    // Attribute picked by a selection code; unused codes fall back to capacity.
    function automatic logic [7:0] pick_attr(input listing_t l, input logic [1:0] key);
        logic [7:0] r;
        begin
            case (key)
                KEY_BEDRM: r = l.bedrooms;
                KEY_BEDS:  r = l.beds;
                default:   r = l.accommodates;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- rtl/core/knn_store.sv -----
// Listing memory with its fill count; one write and one registered read port.
// Depends on knn_pkg.
module knn_store #(
    parameter int MAX_LISTINGS = knn_pkg::DEF_MAX_LISTINGS,
    parameter int AW = $clog2(MAX_LISTINGS),
    parameter int CW = $clog2(MAX_LISTINGS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  knn_pkg::listing_t wr_data,
    input  logic              clear,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output knn_pkg::listing_t rd_data,
    output logic [CW-1:0]     count
);
    import knn_pkg::*;

    localparam logic [CW-1:0] FULL = CW'(MAX_LISTINGS);

    listing_t      mem [MAX_LISTINGS];
    listing_t      rd_data_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_write;

    // A load into a full store is dropped.
    assign do_write = wr_en && (count_reg != FULL);

    always_comb
    begin
        count_next = count_reg;
        if (clear)
        begin
            count_next = '0;
        end
        else if (do_write)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // The memory itself: write at the fill count, registered read.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[count_reg[AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign count   = count_reg;

endmodule

// ----- rtl/core/knn_sorter.sv -----
// Row of insertion cells that keeps the nearest listings in ascending distance.
// Depends on knn_pkg.
module knn_sorter #(
    parameter int MAX_K = knn_pkg::DEF_MAX_K,
    parameter int KW = (MAX_K > 1) ? $clog2(MAX_K) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic          ins_en,
    input  logic [7:0]    ins_dist,
    input  logic [15:0]   ins_price,
    input  logic [KW-1:0] sel,
    output logic [15:0]   sel_price
);
    import knn_pkg::*;

    logic [7:0]  dist_reg  [MAX_K];
    logic [15:0] price_reg [MAX_K];
    logic        valid_reg [MAX_K];
    logic        le        [MAX_K];

    // A cell stays when it holds a listing no farther than the new one;
    // equal distances keep the earlier load in front.
    always_comb
    begin
        for (int i = 0; i < MAX_K; i++)
        begin
            le[i] = valid_reg[i] && (dist_reg[i] <= ins_dist);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_K; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (clear)
        begin
            for (int i = 0; i < MAX_K; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (ins_en)
        begin
            for (int i = 0; i < MAX_K; i++)
            begin
                if (!le[i])
                begin
                    if (i == 0 || le[(i > 0) ? i - 1 : 0])
                    begin
                        valid_reg[i] <= 1'b1;
                    end
                    else
                    begin
                        valid_reg[i] <= valid_reg[(i > 0) ? i - 1 : 0];
                    end
                end
            end
        end
    end

    // Payload of the cells: insert at the first farther cell, shift the rest.
    always_ff @(posedge clk)
    begin
        if (ins_en && !clear)
        begin
            for (int i = 0; i < MAX_K; i++)
            begin
                if (!le[i])
                begin
                    if (i == 0 || le[(i > 0) ? i - 1 : 0])
                    begin
                        dist_reg[i]  <= ins_dist;
                        price_reg[i] <= ins_price;
                    end
                    else
                    begin
                        dist_reg[i]  <= dist_reg[(i > 0) ? i - 1 : 0];
                        price_reg[i] <= price_reg[(i > 0) ? i - 1 : 0];
                    end
                end
            end
        end
    end

    assign sel_price = price_reg[sel];

endmodule

// ----- rtl/core/knn_divider.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on knn_pkg.
module knn_divider #(
    parameter int DW = 29,
    parameter int VW = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    import knn_pkg::*;

    localparam int NW = $clog2(DW + 1);

    logic [VW:0]   rem_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] dvs_reg;
    logic [NW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [VW:0]   rem_sh;
    logic          fit;

    // One shift-subtract step.
    assign rem_sh = {rem_reg[VW-1:0], quo_reg[DW-1]};
    assign fit    = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + NW'(1);
                if (cnt_reg == NW'(DW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= fit ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            quo_reg <= {quo_reg[DW-2:0], fit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/core/knn_price_estimator.sv -----
// Top level of the k-nearest-neighbour price estimator.
// Depends on knn_pkg, knn_store, knn_sorter and knn_divider.
//
// A load or clear transaction leaves busy low. A query raises busy, reads each
// of the count stored listings (one memory read per cycle through the single
// read port), sums the k nearest neighbours one per cycle, and divides in the
// bit-serial divider, whose dividend width DW is 30 at the default sizes. A
// query on an empty store answers in the cycle after it is accepted. The
// result shows for one cycle with done high and cannot be held off by the
// receiver.
module knn_price_estimator #(
    parameter int MAX_LISTINGS = knn_pkg::DEF_MAX_LISTINGS,
    parameter int MAX_K        = knn_pkg::DEF_MAX_K
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [7:0]  accommodates,
    input  logic [7:0]  bedrooms,
    input  logic [7:0]  beds,
    input  logic [15:0] price,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    output logic        done,
    output logic [23:0] mean_price_q8,
    output logic [5:0]  neighbours_used,
    output logic [1:0]  status
);
    import knn_pkg::*;

    localparam int AW   = $clog2(MAX_LISTINGS);
    localparam int CW   = $clog2(MAX_LISTINGS + 1);
    localparam int KW   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int KCW  = $clog2(MAX_K + 1);
    localparam int SW   = 16 + KCW;
    localparam int DW   = SW + 8;
    localparam int CMPW = (CW > 7) ? CW : 7;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]     state_reg, state_next;
    logic [1:0]     key_reg;
    logic [5:0]     k_cfg_reg;
    logic [7:0]     qval_reg;
    logic [KCW-1:0] k_reg;
    logic [1:0]     stat_reg;
    logic [AW-1:0]  addr_reg;
    logic           issue_reg;
    logic           rdv_reg;
    logic [KCW-1:0] idx_reg;
    logic [SW-1:0]  sum_reg;
    logic [23:0]    mean_reg;
    logic [5:0]     used_reg;

    logic           accept;
    listing_t       in_listing;
    listing_t       rd_data;
    logic [CW-1:0]  count;
    logic [6:0]     k_sat;
    logic [7:0]     attr_rd;
    logic [7:0]     dist_rd;
    logic [15:0]    sel_price;
    logic           div_done;
    logic [DW-1:0]  quotient;
    logic           sorter_clear;

    assign accept     = start && (state_reg == S_IDLE);
    assign busy       = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign in_listing = '{accommodates: accommodates, bedrooms: bedrooms,
                          beds: beds, price: price};

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= KEY_RESET;
            k_cfg_reg <= K_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_KEY_SELECT)
            begin
                key_reg <= cfg_data[1:0];
            end
            else if (cfg_index == REG_NEIGHBOURS)
            begin
                k_cfg_reg <= cfg_data;
            end
        end
    end

    // Requested k: zero means one, then saturate at MAX_K.
    always_comb
    begin
        k_sat = (k_cfg_reg == 6'd0) ? 7'd1 : {1'b0, k_cfg_reg};
        if (k_sat > 7'(MAX_K))
        begin
            k_sat = 7'(MAX_K);
        end
    end

    knn_store #(.MAX_LISTINGS(MAX_LISTINGS), .AW(AW), .CW(CW)) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && (opcode == OP_LOAD)),
        .wr_data (in_listing),
        .clear   (accept && (opcode == OP_CLEAR)),
        .rd_en   (issue_reg),
        .rd_addr (addr_reg),
        .rd_data (rd_data),
        .count   (count)
    );

    // Distance of the listing just read from memory.
    assign attr_rd = pick_attr(rd_data, key_reg);
    assign dist_rd = (attr_rd > qval_reg) ? (attr_rd - qval_reg) : (qval_reg - attr_rd);
    assign sorter_clear = accept && (opcode == OP_QUERY);

    knn_sorter #(.MAX_K(MAX_K), .KW(KW)) u_sorter (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (sorter_clear),
        .ins_en    (rdv_reg),
        .ins_dist  (dist_rd),
        .ins_price (rd_data.price),
        .sel       (idx_reg[KW-1:0]),
        .sel_price (sel_price)
    );

    knn_divider #(.DW(DW), .VW(KCW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    ((state_reg == S_SUM) && (idx_reg == k_reg - KCW'(1))),
        .dividend ({sum_reg + SW'(sel_price), 8'd0}),
        .divisor  (k_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Query sequencer state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (opcode == OP_QUERY))
                begin
                    state_next = (count == '0) ? S_DONE : S_WALK;
                end
            end
            S_WALK:
            begin
                if (!issue_reg && !rdv_reg)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (idx_reg == k_reg - KCW'(1))
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            issue_reg <= 1'b0;
            rdv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rdv_reg   <= issue_reg;
            if (accept && (opcode == OP_QUERY) && (count != '0))
            begin
                issue_reg <= 1'b1;
            end
            else if (issue_reg && ({1'b0, addr_reg} == CW'(count - CW'(1))))
            begin
                issue_reg <= 1'b0;
            end
        end
    end

    // Query operands, walk address, running sum and result.
    always_ff @(posedge clk)
    begin
        if (accept && (opcode == OP_QUERY))
        begin
            qval_reg <= pick_attr(in_listing, key_reg);
            addr_reg <= '0;
            if (count == '0)
            begin
                k_reg    <= '0;
                stat_reg <= ST_EMPTY;
                mean_reg <= '0;
                used_reg <= '0;
            end
            else if (CMPW'(k_sat) > CMPW'(count))
            begin
                k_reg    <= KCW'(count);
                stat_reg <= ST_REDUCED;
            end
            else
            begin
                k_reg    <= KCW'(k_sat);
                stat_reg <= ST_OK;
            end
        end
        else if (issue_reg)
        begin
            addr_reg <= addr_reg + AW'(1);
        end
        if (state_reg == S_WALK)
        begin
            idx_reg <= '0;
            sum_reg <= '0;
        end
        else if (state_reg == S_SUM)
        begin
            idx_reg <= idx_reg + KCW'(1);
            sum_reg <= sum_reg + SW'(sel_price);
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            mean_reg <= quotient[23:0];
            used_reg <= 6'(k_reg);
        end
    end

    assign done            = (state_reg == S_DONE);
    assign mean_price_q8   = mean_reg;
    assign neighbours_used = used_reg;
    assign status          = stat_reg;

endmodule

// ----- rtl/core/knn_checker.sv -----
// Port-level checker of the price estimator, bound to the top level.
// Depends on knn_pkg and knn_price_estimator_defines.svh.
`include "knn_price_estimator_defines.svh"

module knn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  opcode,
    input logic        done,
    input logic [23:0] mean_price_q8,
    input logic [5:0]  neighbours_used,
    input logic [1:0]  status
);
    import knn_pkg::*;

    // A result only ends a query that holds the block busy.
    `KNN_ASSERT_NOW(a_done_after_busy, done, busy)
    // An accepted query always makes the block busy.
    `KNN_ASSERT_NEXT(a_query_busy, start && !busy && (opcode == OP_QUERY), busy)
    // The block is idle right after a result.
    `KNN_ASSERT_NEXT(a_idle_after_done, done, !busy)
    // An empty store gives a zero mean over no listings.
    `KNN_ASSERT_NOW(a_empty_zero, done && (status == ST_EMPTY), (mean_price_q8 == 24'd0) && (neighbours_used == 6'd0))
    // A result never has status code three.
    `KNN_ASSERT_NOW(a_status_code, done, (status == ST_OK) || (status == ST_EMPTY) || (status == ST_REDUCED))

endmodule

bind knn_price_estimator knn_checker u_knn_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .done            (done),
    .mean_price_q8   (mean_price_q8),
    .neighbours_used (neighbours_used),
    .status          (status)
);

// ----- test/tb.sv -----
// Testbench for knn_price_estimator: drives load, query, clear and invalid ops,
// predicts each query's result and checks it. Depends on knn_pkg and the RTL.
module tb;
    import knn_pkg::*;

    localparam int STORE_DEPTH = DEF_MAX_LISTINGS;
    localparam int K_LIMIT     = DEF_MAX_K;
    localparam int CYCLE_LIMIT = 900000;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  accom;
        logic [7:0]  bedrm;
        logic [7:0]  nbeds;
        logic [15:0] cost;
    } command_t;

    typedef struct packed {
        logic [23:0] mean;
        logic [5:0]  used;
        logic [1:0]  st;
    } estimate_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [7:0]  accommodates;
    logic [7:0]  bedrooms;
    logic [7:0]  beds;
    logic [15:0] price;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [5:0]  cfg_data;
    logic        done;
    logic [23:0] mean_price_q8;
    logic [5:0]  neighbours_used;
    logic [1:0]  status;

    knn_price_estimator i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .opcode(opcode),
        .accommodates(accommodates), .bedrooms(bedrooms), .beds(beds), .price(price),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .mean_price_q8(mean_price_q8),
        .neighbours_used(neighbours_used), .status(status)
    );

    // Predictor state: stored listings and register copies.
    listing_t    shadow_store [STORE_DEPTH];
    int unsigned shadow_count;
    logic [1:0]  shadow_key;
    logic [5:0]  shadow_k;

    command_t    pending_cmds[$];
    estimate_t   expected_estimates[$];
    int          error_count;
    int          cycle_count;
    int          idle_left;
    bit          idle_enable;
    logic        cfg_pending;
    logic [1:0]  cfg_idx_req;
    logic [5:0]  cfg_val_req;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            error_count++;
        end
    endtask

    function automatic logic [7:0] key_attr(input listing_t l, input logic [1:0] key);
        logic [7:0] r;
        begin
            if (key == KEY_BEDRM) r = l.bedrooms;
            else if (key == KEY_BEDS) r = l.beds;
            else r = l.accommodates;
            return r;
        end
    endfunction

    // Apply one accepted command to the predictor; queries queue an estimate.
    task automatic predict_command(input command_t c);
        estimate_t   e;
        int unsigned k, taken, d;
        logic [63:0] total;
        logic [7:0]  qv, lv;
        listing_t    qref;
        begin
            if (c.op == OP_LOAD)
            begin
                if (shadow_count < STORE_DEPTH)
                begin
                    shadow_store[shadow_count] = {c.accom, c.bedrm, c.nbeds, c.cost};
                    shadow_count++;
                end
            end
            else if (c.op == OP_CLEAR)
                shadow_count = 0;
            else if (c.op == OP_QUERY)
            begin
                if (shadow_count == 0)
                    e = '{mean: 24'd0, used: 6'd0, st: ST_EMPTY};
                else
                begin
                    k = (shadow_k == 0) ? 1 : shadow_k;
                    if (k > K_LIMIT) k = K_LIMIT;
                    e.st = ST_OK;
                    if (k > shadow_count)
                    begin
                        k = shadow_count;
                        e.st = ST_REDUCED;
                    end
                    qref = {c.accom, c.bedrm, c.nbeds, c.cost};
                    qv = key_attr(qref, shadow_key);
                    total = 0;
                    taken = 0;
                    // Nearest first; equal distances in load order.
                    for (d = 0; d < 256 && taken < k; d++)
                        for (int i = 0; i < shadow_count && taken < k; i++)
                        begin
                            lv = key_attr(shadow_store[i], shadow_key);
                            if (((qv > lv) ? qv - lv : lv - qv) == d)
                            begin
                                total += shadow_store[i].price;
                                taken++;
                            end
                        end
                    e.mean = 24'((total << 8) / taken);
                    e.used = 6'(taken);
                end
                expected_estimates.push_back(e);
            end
        end
    endtask

    function automatic command_t rand_cmd(input logic [1:0] op, input int span);
        command_t c;
        begin
            c.op    = op;
            c.accom = (span >= 255) ? 8'($urandom) : 8'($urandom_range(0, span));
            c.bedrm = (span >= 255) ? 8'($urandom) : 8'($urandom_range(0, span));
            c.nbeds = (span >= 255) ? 8'($urandom) : 8'($urandom_range(0, span));
            c.cost  = 16'($urandom);
            return c;
        end
    endfunction

    // Command driver with random idle bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            idle_left <= 0;
        end
        else
        begin
            if (start && !busy)
                predict_command({opcode, accommodates, bedrooms, beds, price});
            if (start && busy)
                ;
            else if (idle_left > 0)
            begin
                start     <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (pending_cmds.size() > 0)
            begin
                {opcode, accommodates, bedrooms, beds, price} <= pending_cmds.pop_front();
                start <= 1'b1;
                if (idle_enable && $urandom_range(0, 5) == 0)
                    idle_left <= $urandom_range(1, 6);
            end
            else
                start <= 1'b0;
        end
    end

    // Configuration channel: a request is held until ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_valid <= 1'b0;
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_KEY_SELECT) shadow_key = cfg_data[1:0];
            else if (cfg_index == REG_NEIGHBOURS) shadow_k = cfg_data;
            cfg_valid   <= 1'b0;
            cfg_pending <= 1'b0;
        end
        else if (cfg_pending && !cfg_valid)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_idx_req;
            cfg_data  <= cfg_val_req;
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        estimate_t e;
        if (rst_n && done)
        begin
            if (expected_estimates.size() == 0)
            begin
                $display("unexpected estimate transaction");
                error_count++;
            end
            else
            begin
                e = expected_estimates.pop_front();
                if (mean_price_q8 !== e.mean)
                    report_mismatch("mean_price_q8", mean_price_q8, e.mean);
                if (neighbours_used !== e.used)
                    report_mismatch("neighbours_used", neighbours_used, e.used);
                if (status !== e.st)
                    report_mismatch("status", status, e.st);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[knn_price_estimator] ERROR");
            $finish;
        end
    end

    // Checked at the falling edge, where driver and block outputs are settled.
    task automatic wait_drained();
        begin
            while (pending_cmds.size() > 0 || start || busy || expected_estimates.size() > 0)
                @(negedge clk);
            repeat (60) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
        begin
            wait_drained();
            cfg_idx_req = idx;
            cfg_val_req = val;
            cfg_pending = 1'b1;
            while (cfg_pending) @(posedge clk);
        end
    endtask

    // One random phase: a random mix of loads and queries, some clears and opcode three.
    task automatic random_phase(input int n, input int span);
        int r;
        begin
            for (int i = 0; i < n; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 55) pending_cmds.push_back(rand_cmd(OP_LOAD, span));
                else if (r < 90) pending_cmds.push_back(rand_cmd(OP_QUERY, span));
                else if (r < 94) pending_cmds.push_back(rand_cmd(OP_CLEAR, 255));
                else pending_cmds.push_back(rand_cmd(2'd3, 255));
            end
        end
    endtask

    initial
    begin
        command_t c;
        rst_n = 1'b0; start = 1'b0; cfg_valid = 1'b0; cfg_pending = 1'b0;
        opcode = OP_LOAD; accommodates = 0; bedrooms = 0; beds = 0; price = 0;
        cfg_index = REG_KEY_SELECT; cfg_data = 0;
        shadow_count = 0; shadow_key = KEY_RESET; shadow_k = K_RESET;
        error_count = 0; cycle_count = 0; idle_enable = 1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty query, extremes, ties, opcode three, clear.
        pending_cmds.push_back(rand_cmd(OP_QUERY, 255));
        pending_cmds.push_back('{OP_LOAD, 8'd0, 8'd0, 8'd0, 16'd0});
        pending_cmds.push_back('{OP_LOAD, 8'd255, 8'd255, 8'd255, 16'hFFFF});
        pending_cmds.push_back('{OP_LOAD, 8'd3, 8'd3, 8'd3, 16'd100});
        pending_cmds.push_back('{OP_LOAD, 8'd5, 8'd5, 8'd5, 16'd7});
        pending_cmds.push_back('{OP_LOAD, 8'd3, 8'd3, 8'd3, 16'd300});
        pending_cmds.push_back('{OP_QUERY, 8'd4, 8'd4, 8'd4, 16'd0});
        pending_cmds.push_back('{2'd3, 8'hAA, 8'h55, 8'hAA, 16'h5555});
        pending_cmds.push_back('{OP_QUERY, 8'd255, 8'd0, 8'd128, 16'hFFFF});
        for (int i = 0; i < 4; i++) pending_cmds.push_back(rand_cmd(OP_LOAD, 255));
        pending_cmds.push_back('{OP_QUERY, 8'd0, 8'd255, 8'd0, 16'd0});
        pending_cmds.push_back('{OP_CLEAR, 8'd0, 8'd0, 8'd0, 16'd0});
        pending_cmds.push_back('{OP_QUERY, 8'd1, 8'd1, 8'd1, 16'd0});

        // Random phases across register settings, extremes included.
        write_reg(REG_NEIGHBOURS, 6'd1);
        write_reg(REG_KEY_SELECT, KEY_BEDRM);
        random_phase(50, 7);
        write_reg(REG_NEIGHBOURS, 6'd32);
        write_reg(REG_KEY_SELECT, KEY_BEDS);
        random_phase(50, 255);
        write_reg(REG_NEIGHBOURS, 6'd0);
        write_reg(REG_KEY_SELECT, 2'd3);
        random_phase(40, 15);
        write_reg(REG_NEIGHBOURS, 6'd63);
        write_reg(REG_KEY_SELECT, KEY_ACCOM);
        random_phase(50, 3);
        // Fill beyond capacity to exercise dropped loads.
        wait_drained();
        pending_cmds.push_back('{OP_CLEAR, 8'd0, 8'd0, 8'd0, 16'd0});
        for (int i = 0; i < 262; i++) pending_cmds.push_back(rand_cmd(OP_LOAD, 255));
        for (int i = 0; i < 6; i++) pending_cmds.push_back(rand_cmd(OP_QUERY, 255));
        write_reg(REG_NEIGHBOURS, 6'($urandom_range(2, 31)));
        pending_cmds.push_back('{OP_CLEAR, 8'd0, 8'd0, 8'd0, 16'd0});
        random_phase(40, 31);
        wait_drained();
        idle_enable = 0;
        random_phase(40, 255);
        wait_drained();

        if (error_count == 0)
            $display("[knn_price_estimator] OK");
        else
            $display("[knn_price_estimator] ERROR");
        $finish;
    end
endmodule
